>>> rtl/core/ffud_pkg.sv
// Shared types and character constants for the form field URL decoder.
package ffud_pkg;

  typedef enum logic [1:0] {
    PCT_NONE   = 2'd0,
    PCT_FIRST  = 2'd1,
    PCT_SECOND = 2'd2
  } pct_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_value_part;
    logic       ends_pair;
    logic       ends_string;
    logic       run_last;
  } res_t;

  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  localparam logic [7:0] DELIM_RESET = 8'h26;

  localparam logic CFG_DELIM = 1'b0;
  localparam logic CFG_STRIP = 1'b1;

  localparam int QDEPTH = 4;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
        hex_decode = {1'b1, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        t = c - 8'h57;
        hex_decode = {1'b1, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        t = c - 8'h37;
        hex_decode = {1'b1, t[3:0]};
      end else begin
        hex_decode = 5'd0;
      end
    end
  endfunction

endpackage

>>> rtl/core/form_field_url_decoder.sv
// Form field URL decoder: splits an encoded query or cookie string into name and value bytes.
// Accepts one input byte per cycle while in_stall is low; its results (zero, one or two) are
// written into a four-entry result queue. The output port delivers one result per cycle
// while out_stall is low, so a run of bytes that each give two results is paced by the
// output; in_stall rises while more than two results are queued. A string with no results
// still ends with one end-of-string result.
module form_field_url_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       in_value_part,
  output logic       ends_pair,
  output logic       ends_string,
  output logic       run_last
);

  // configuration
  logic [7:0] pair_delimiter;
  logic       strip_space;

  // parse state
  logic             token_open, token_open_next;
  logic             value_phase, value_phase_next;
  ffud_pkg::pct_t   pct, pct_next;
  logic [7:0]       acc, acc_next;
  logic             first_ok, first_ok_next;
  logic             after_delim, after_delim_next;

  // state after the byte itself, before end-of-string handling
  logic             body_tok, body_val, body_fok;
  ffud_pkg::pct_t   body_pct;
  logic [7:0]       body_acc;

  ffud_pkg::res_t   q [ffud_pkg::QDEPTH];
  ffud_pkg::res_t   q_next [ffud_pkg::QDEPTH];
  logic [2:0]       count, count_next;

  ffud_pkg::res_t   r0, r1;
  logic [1:0]       n_res;

  logic       in_acc, out_acc;
  logic       is_strip, is_delim;
  logic [4:0] hd;
  logic [2:0] base;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (count > 3'd2);
  assign out_valid = (count != 3'd0);

  assign is_strip = strip_space && after_delim && (in_byte == ffud_pkg::CH_SPACE);
  assign is_delim = !is_strip && (in_byte == pair_delimiter);
  assign hd       = ffud_pkg::hex_decode(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_delimiter <= ffud_pkg::DELIM_RESET;
      strip_space    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ffud_pkg::CFG_DELIM: pair_delimiter <= cfg_data;
        ffud_pkg::CFG_STRIP: strip_space    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    body_tok = token_open;
    body_val = value_phase;
    body_pct = pct;
    body_acc = acc;
    body_fok = first_ok;
    after_delim_next = after_delim;
    if (is_strip) begin
      after_delim_next = 1'b0;
    end else if (is_delim) begin
      after_delim_next = 1'b1;
      if (token_open) begin
        body_tok = 1'b0;
        body_val = 1'b0;
        body_pct = ffud_pkg::PCT_NONE;
        body_acc = 8'd0;
        body_fok = 1'b0;
      end
    end else begin
      after_delim_next = 1'b0;
      if (!token_open) begin
        body_tok = 1'b1;
        body_val = 1'b0;
      end
      case (pct)
        ffud_pkg::PCT_FIRST: begin
          body_fok = hd[4];
          body_acc = hd[4] ? {4'd0, hd[3:0]} : 8'd0;
          body_pct = ffud_pkg::PCT_SECOND;
        end
        ffud_pkg::PCT_SECOND: begin
          body_pct = ffud_pkg::PCT_NONE;
          body_acc = 8'd0;
          body_fok = 1'b0;
        end
        default: begin
          if (!value_phase) begin
            if (in_byte == ffud_pkg::CH_EQUAL) body_val = 1'b1;
          end else if (in_byte == ffud_pkg::CH_PERCENT) begin
            body_pct = ffud_pkg::PCT_FIRST;
          end
        end
      endcase
    end

    if (is_final) begin
      token_open_next  = 1'b0;
      value_phase_next = 1'b0;
      pct_next         = ffud_pkg::PCT_NONE;
      acc_next         = 8'd0;
      first_ok_next    = 1'b0;
      after_delim_next = 1'b0;
    end else begin
      token_open_next  = body_tok;
      value_phase_next = body_val;
      pct_next         = body_pct;
      acc_next         = body_acc;
      first_ok_next    = body_fok;
    end
  end

  // results of the current byte
  always_comb begin
    ffud_pkg::res_t rs [2];
    ffud_pkg::res_t t;
    logic [1:0] n;
    logic [7:0] v;
    rs[0] = '0;
    rs[1] = '0;
    n = 2'd0;
    t = '0;
    v = 8'd0;

    if (is_strip) begin
      n = 2'd0;
    end else if (is_delim) begin
      if (token_open) begin
        if (pct != ffud_pkg::PCT_NONE) begin
          t = '0;
          t.out_byte = (pct == ffud_pkg::PCT_SECOND && first_ok) ? acc : ffud_pkg::CH_QUESTION;
          t.has_byte = 1'b1;
          t.in_value_part = 1'b1;
          rs[n[0]] = t;
          n = n + 2'd1;
        end
        t = '0;
        t.in_value_part = value_phase;
        t.ends_pair = 1'b1;
        rs[n[0]] = t;
        n = n + 2'd1;
      end
    end else begin
      case (pct)
        ffud_pkg::PCT_FIRST: n = 2'd0;
        ffud_pkg::PCT_SECOND: begin
          if (!first_ok) v = ffud_pkg::CH_QUESTION;
          else if (hd[4]) v = {acc[3:0], hd[3:0]};
          else v = acc;
          t = '0;
          t.out_byte = v;
          t.has_byte = 1'b1;
          t.in_value_part = 1'b1;
          rs[0] = t;
          n = 2'd1;
        end
        default: begin
          t = '0;
          t.has_byte = 1'b1;
          t.in_value_part = value_phase;
          t.out_byte = in_byte;
          if (!value_phase) begin
            if (in_byte != ffud_pkg::CH_EQUAL) begin
              rs[0] = t;
              n = 2'd1;
            end
          end else if (in_byte == ffud_pkg::CH_PLUS) begin
            t.out_byte = ffud_pkg::CH_SPACE;
            rs[0] = t;
            n = 2'd1;
          end else if (in_byte != ffud_pkg::CH_PERCENT) begin
            rs[0] = t;
            n = 2'd1;
          end
        end
      endcase
    end

    if (is_final) begin
      if (body_tok) begin
        if (body_pct != ffud_pkg::PCT_NONE) begin
          t = '0;
          t.out_byte = (body_pct == ffud_pkg::PCT_SECOND && body_fok) ? body_acc
                                                                      : ffud_pkg::CH_QUESTION;
          t.has_byte = 1'b1;
          t.in_value_part = 1'b1;
          rs[n[0]] = t;
          n = n + 2'd1;
        end
        t = '0;
        t.in_value_part = body_val;
        t.ends_pair = 1'b1;
        t.ends_string = 1'b1;
        rs[n[0]] = t;
        n = n + 2'd1;
      end else if (n != 2'd0) begin
        rs[n[0] ^ 1'b1].ends_string = 1'b1;
      end else begin
        t = '0;
        t.ends_string = 1'b1;
        rs[0] = t;
        n = 2'd1;
      end
    end

    if (n != 2'd0) rs[n[0] ^ 1'b1].run_last = 1'b1;
    // two results: n wraps index parity, so the last one is rs[1]
    if (n == 2'd2) rs[1].run_last = 1'b1;

    r0 = rs[0];
    r1 = rs[1];
    n_res = n;
  end

  // result queue, head at entry 0
  assign base = count - {2'd0, out_acc};

  always_comb begin
    for (int i = 0; i < ffud_pkg::QDEPTH; i++) begin
      if (out_acc && i < ffud_pkg::QDEPTH - 1) q_next[i] = q[(i + 1) % ffud_pkg::QDEPTH];
      else q_next[i] = q[i];
      if (in_acc && n_res != 2'd0 && base == 3'(i)) q_next[i] = r0;
      if (in_acc && n_res == 2'd2 && (base + 3'd1) == 3'(i)) q_next[i] = r1;
    end
    count_next = base + ((in_acc) ? {1'b0, n_res} : 3'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ffud_pkg::QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= 3'd0;
      token_open  <= 1'b0;
      value_phase <= 1'b0;
      pct         <= ffud_pkg::PCT_NONE;
      acc         <= 8'd0;
      first_ok    <= 1'b0;
      after_delim <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        token_open  <= token_open_next;
        value_phase <= value_phase_next;
        pct         <= pct_next;
        acc         <= acc_next;
        first_ok    <= first_ok_next;
        after_delim <= after_delim_next;
      end
    end
  end

  assign out_byte      = q[0].out_byte;
  assign has_byte      = q[0].has_byte;
  assign in_value_part = q[0].in_value_part;
  assign ends_pair     = q[0].ends_pair;
  assign ends_string   = q[0].ends_string;
  assign run_last      = q[0].run_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(ffud_pkg::QDEPTH))
    else $error("result queue overflow");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_final) |=> (!token_open && pct == ffud_pkg::PCT_NONE && !after_delim))
    else $error("parse state not cleared after final byte");

  a_escape_in_value: assert property (@(posedge clk) disable iff (rst)
    (pct != ffud_pkg::PCT_NONE) |-> (token_open && value_phase))
    else $error("escape pending outside a value");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_byte || out_byte == 8'd0))
    else $error("byte present on a result without data");

  a_string_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ends_string) |-> run_last)
    else $error("end of string not on last result of its item");

endmodule
